FILE: sv/drt_pkg.sv
// Package: constants, types and the function codes of the device registry table.
package drt_pkg;
	localparam int TABLE_DEPTH_DEF = 128;
	localparam int CLASS_COUNT_DEF = 16;
	localparam int NAME_BITS = 256;
	localparam int NAME_STORE_BITS = 248;
	localparam int ENTRY_BITS = 4 + 32 + 128 + 8 + NAME_STORE_BITS;

	typedef enum logic [3:0] {
		FN_ADD = 4'd0, FN_REMOVE = 4'd1, FN_COUNT_ALL = 4'd2, FN_COUNT_CLASS = 4'd3,
		FN_NTH = 4'd4, FN_CLASS = 4'd5, FN_UNIT = 4'd6, FN_BUS = 4'd7,
		FN_LOCATION = 4'd8, FN_NAME = 4'd9
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_SCAN_LAST, ST_ADD_CNT, ST_ADD_CNT2, ST_ADD_WR, ST_QRY, ST_DONE
	} state_t;

	typedef struct packed {
		logic [3:0]                 cls;
		logic [31:0]                bus;
		logic [127:0]               loc;
		logic [7:0]                 unit;
		logic [NAME_STORE_BITS-1:0] name;
	} entry_t;

	// Stored form of a name: bytes up to the first zero, at most 31.
	function automatic logic [NAME_STORE_BITS-1:0] name_trunc(input logic [NAME_BITS-1:0] n);
		logic [NAME_STORE_BITS-1:0] r;
		logic live;
		r = '0;
		live = 1'b1;
		for (int k = 0; k < 31; k++) begin
			if (n[8*k +: 8] == 8'd0) live = 1'b0;
			if (live) r[8*k +: 8] = n[8*k +: 8];
		end
		return r;
	endfunction
endpackage

FILE: sv/drt_ram.sv
// Generic single-port synchronous RAM with registered read.
module drt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

FILE: sv/device_registry_table.sv
// Device registry table: entries in one RAM, valid bits and class counts in flops.
// Count all, nth of class and add walk every slot, one slot per cycle on the RAM's single
// port; a new entry is then written. Other requests read only the selected slot.
// Busy drops with the strobe, so the next transaction can be presented while the strobe is high;
// results are one-cycle strobes, the receiver cannot stall. Reset clears valid bits
// and class counts (arst_n low); no clearing pass.
module device_registry_table
	import drt_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int CLASS_COUNT = CLASS_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  func,
	input  logic [3:0]  class_code,
	input  logic signed [31:0] bus_number,
	input  logic [31:0] location_a,
	input  logic [31:0] location_b,
	input  logic [31:0] location_c,
	input  logic [31:0] location_d,
	input  logic [63:0] name_word_0,
	input  logic [63:0] name_word_1,
	input  logic [63:0] name_word_2,
	input  logic [63:0] name_word_3,
	input  logic [7:0]  slot_select,
	output logic        done,
	output logic        failed,
	output logic [31:0] answer_value,
	output logic [63:0] name_out_0,
	output logic [63:0] name_out_1,
	output logic [63:0] name_out_2,
	output logic [63:0] name_out_3
);
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int CCW = $clog2(CLASS_COUNT);

	state_t state_q, state_d;

	// captured request
	logic [3:0]           func_q;
	logic [3:0]           cls_q;
	logic [31:0]          bus_q;
	logic [127:0]         loc_q;
	logic [NAME_BITS-1:0] name_q;
	logic [7:0]           sel_q;

	logic [TABLE_DEPTH-1:0] valid_q;
	logic [7:0]             ccount_q [CLASS_COUNT];

	// walk
	logic [AW-1:0] addr_q;      // address presented to RAM
	logic [AW-1:0] raddr_s1;    // address of data now on rdata
	logic          rvld_s1;
	logic          hit_q;
	logic [AW-1:0] hit_slot_q;
	logic          free_q;
	logic [AW-1:0] free_slot_q;
	logic [CW-1:0] cnt_q;       // total count or rank seen
	logic [7:0]    unit_q;

	logic   we;
	logic [AW-1:0] ram_addr;
	entry_t wentry, rentry;

	drt_ram #(.WIDTH(ENTRY_BITS), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk(clk), .we(we), .addr(ram_addr), .wdata(wentry), .rdata(rentry)
	);

	// match of one stored entry against the request
	logic name_eq, entry_eq, live_n;
	always_comb begin
		name_eq = 1'b1;
		live_n = 1'b1;
		for (int k = 0; k < 32; k++) begin
			if (live_n) begin
				if (((k < 31) ? rentry.name[8*(k%31) +: 8] : 8'd0) != name_q[8*k +: 8])
					name_eq = 1'b0;
				if (name_q[8*k +: 8] == 8'd0 ||
					((k < 31) ? rentry.name[8*(k%31) +: 8] : 8'd0) != name_q[8*k +: 8])
					live_n = 1'b0;
			end
		end
		entry_eq = rentry.cls == cls_q && rentry.bus == bus_q && rentry.loc == loc_q && name_eq;
	end

	logic [AW-1:0] sel_idx;
	logic req_cls_ok, sel_ok, slot_ok;
	assign sel_idx = AW'(sel_q);
	assign req_cls_ok = cls_q != 4'd0 && 32'(cls_q) < CLASS_COUNT;
	assign sel_ok = 32'(sel_q) < TABLE_DEPTH;
	assign slot_ok = sel_ok && valid_q[sel_idx];

	logic [CCW-1:0] cidx, ecidx;
	assign cidx = CCW'(cls_q);
	assign ecidx = CCW'(rentry.cls);

	// single-slot result: slot data read in ST_SCAN, judged in ST_QRY, held for ST_DONE
	logic         qry_fail;
	logic [31:0]  qry_ans;
	logic [255:0] qry_name;
	always_comb begin
		qry_fail = 1'b1;
		qry_ans = '0;
		qry_name = '0;
		case (func_q)
			FN_REMOVE: if (slot_ok) qry_fail = 1'b0;
			FN_COUNT_CLASS: if (req_cls_ok) begin
				qry_fail = 1'b0;
				qry_ans = 32'(ccount_q[cidx]);
			end
			FN_CLASS: if (slot_ok) begin
				qry_fail = 1'b0;
				qry_ans = 32'(rentry.cls);
			end
			FN_UNIT: if (slot_ok) begin
				qry_fail = 1'b0;
				qry_ans = 32'(rentry.unit);
			end
			FN_BUS: if (slot_ok) begin
				qry_fail = 1'b0;
				qry_ans = rentry.bus;
			end
			FN_LOCATION: if (slot_ok && loc_q[31:0] <= 32'd3) begin
				qry_fail = 1'b0;
				qry_ans = rentry.loc[32*loc_q[1:0] +: 32];
			end
			FN_NAME: if (slot_ok) begin
				qry_fail = 1'b0;
				qry_name = {8'd0, rentry.name};
			end
			default: ;
		endcase
	end

	logic         q_fail_q;
	logic [31:0]  q_ans_q;
	logic [255:0] q_name_q;
	always_ff @(posedge clk) begin
		if (state_q == ST_QRY) begin
			q_fail_q <= qry_fail;
			q_ans_q <= qry_ans;
			q_name_q <= qry_name;
		end
	end

	logic is_walk;
	assign is_walk = func_q == FN_ADD || func_q == FN_COUNT_ALL || func_q == FN_NTH;

	// result picked in ST_DONE: walk results from the scan registers, else the held query
	logic         res_fail;
	logic [31:0]  res_ans;
	logic [255:0] res_name;
	always_comb begin
		res_fail = q_fail_q;
		res_ans = q_ans_q;
		res_name = q_name_q;
		if (is_walk) begin
			res_fail = 1'b1;
			res_ans = '0;
			res_name = '0;
			case (func_q)
				FN_ADD: if (req_cls_ok && name_q[7:0] != 8'd0) begin
					if (hit_q) begin
						res_fail = 1'b0;
						res_ans = 32'(hit_slot_q);
					end else if (free_q) begin
						res_fail = 1'b0;
						res_ans = 32'(free_slot_q);
					end
				end
				FN_COUNT_ALL: begin
					res_fail = 1'b0;
					res_ans = 32'(cnt_q);
				end
				FN_NTH: if (cls_q != 4'd0 && hit_q) begin
					res_fail = 1'b0;
					res_ans = 32'(hit_slot_q);
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		ram_addr = addr_q;
		we = 1'b0;
		wentry.cls = cls_q;
		wentry.bus = bus_q;
		wentry.loc = loc_q;
		wentry.unit = unit_q;
		wentry.name = name_trunc(name_q);
		if (state_q == ST_ADD_WR) begin
			ram_addr = free_slot_q;
			we = 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (start) state_d = ST_SCAN;
			ST_SCAN: begin
				if (func_q == FN_ADD || func_q == FN_COUNT_ALL || func_q == FN_NTH) begin
					if (addr_q == AW'(TABLE_DEPTH - 1)) state_d = ST_SCAN_LAST;
				end else state_d = ST_QRY;
			end
			ST_SCAN_LAST: state_d = (func_q == FN_ADD) ? ST_ADD_CNT : ST_DONE;
			ST_ADD_CNT:   state_d = (hit_q || !free_q || !req_cls_ok || name_q[7:0] == 8'd0)
				? ST_DONE : ST_ADD_CNT2;
			ST_ADD_CNT2:  state_d = ST_ADD_WR;
			ST_ADD_WR:    state_d = ST_DONE;
			ST_QRY:       state_d = ST_DONE;
			ST_DONE:      state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	assign busy = state_q != ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			func_q <= func;
			cls_q <= class_code;
			bus_q <= bus_number;
			loc_q <= {location_d, location_c, location_b, location_a};
			name_q <= {name_word_3, name_word_2, name_word_1, name_word_0};
			sel_q <= slot_select;
		end
	end

	// walk pipeline and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int c = 0; c < CLASS_COUNT; c++) ccount_q[c] <= 8'd0;
			done <= 1'b0;
			failed <= 1'b0;
			answer_value <= '0;
			{name_out_3, name_out_2, name_out_1, name_out_0} <= '0;
			addr_q <= '0;
			raddr_s1 <= '0;
			rvld_s1 <= 1'b0;
			hit_q <= 1'b0;
			hit_slot_q <= '0;
			free_q <= 1'b0;
			free_slot_q <= '0;
			cnt_q <= '0;
			unit_q <= '0;
		end else begin
			done <= state_q == ST_DONE;
			rvld_s1 <= state_q == ST_SCAN;
			case (state_q)
				ST_IDLE: if (start) begin
					addr_q <= (func == FN_ADD || func == FN_COUNT_ALL || func == FN_NTH)
						? '0 : AW'(slot_select);
					hit_q <= 1'b0;
					free_q <= 1'b0;
					cnt_q <= '0;
				end
				ST_SCAN, ST_SCAN_LAST: begin
					if (state_q == ST_SCAN) begin
						raddr_s1 <= addr_q;
						if (addr_q != AW'(TABLE_DEPTH - 1)) addr_q <= addr_q + 1'b1;
					end
					if (rvld_s1) begin
						case (func_q)
							FN_ADD: begin
								if (valid_q[raddr_s1] && entry_eq && !hit_q) begin
									hit_q <= 1'b1;
									hit_slot_q <= raddr_s1;
								end
								if (!valid_q[raddr_s1] && !free_q) begin
									free_q <= 1'b1;
									free_slot_q <= raddr_s1;
								end
							end
							FN_COUNT_ALL: if (valid_q[raddr_s1]) cnt_q <= cnt_q + 1'b1;
							FN_NTH: if (valid_q[raddr_s1] && rentry.cls == cls_q && !hit_q) begin
								if (32'(cnt_q) == 32'(sel_q)) begin
									hit_q <= 1'b1;
									hit_slot_q <= raddr_s1;
								end
								cnt_q <= cnt_q + 1'b1;
							end
							default: ;
						endcase
					end
				end
				ST_ADD_CNT2: unit_q <= ccount_q[cidx];
				ST_ADD_WR: begin
					valid_q[free_slot_q] <= 1'b1;
					if (ccount_q[cidx] != 8'hFF) ccount_q[cidx] <= ccount_q[cidx] + 1'b1;
				end
				// remove: slot data read in ST_SCAN, used here
				ST_QRY: if (func_q == FN_REMOVE && slot_ok) begin
					if (32'(rentry.cls) < CLASS_COUNT && ccount_q[ecidx] != 8'd0)
						ccount_q[ecidx] <= ccount_q[ecidx] - 1'b1;
					valid_q[sel_idx] <= 1'b0;
				end
				ST_DONE: begin
					failed <= res_fail;
					answer_value <= res_ans;
					{name_out_3, name_out_2, name_out_1, name_out_0} <= res_name;
				end
				default: ;
			endcase
		end
	end
endmodule

FILE: test/drt_checker.sv
// Checker for the device registry table: predicts each transaction and compares results.
`timescale 1ns / 100ps
module drt_checker
	import drt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [3:0]  func,
	input  logic [3:0]  class_code,
	input  logic [31:0] bus_number,
	input  logic [31:0] location_a,
	input  logic [31:0] location_b,
	input  logic [31:0] location_c,
	input  logic [31:0] location_d,
	input  logic [63:0] name_word_0,
	input  logic [63:0] name_word_1,
	input  logic [63:0] name_word_2,
	input  logic [63:0] name_word_3,
	input  logic [7:0]  slot_select,
	input  logic        done,
	input  logic        failed,
	input  logic [31:0] answer_value,
	input  logic [63:0] name_out_0,
	input  logic [63:0] name_out_1,
	input  logic [63:0] name_out_2,
	input  logic [63:0] name_out_3,
	output int          errors,
	output int          pending,
	output int          checked,
	output int          adds_done,
	output int          full_hits
);
	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam int NCLS = CLASS_COUNT_DEF;

	typedef struct {
		logic        fail;
		logic [31:0] ans;
		logic [255:0] nm;
	} answer_t;

	// shadow copy of the table
	logic         used[DEPTH];
	logic [3:0]   ent_cls[DEPTH];
	logic [31:0]  ent_bus[DEPTH];
	logic [127:0] ent_loc[DEPTH];
	logic [7:0]   ent_unit[DEPTH];
	logic [255:0] ent_name[DEPTH];
	logic [7:0]   live_cnt[NCLS];

	answer_t expected_q[$];

	function automatic logic names_equal(logic [255:0] a, logic [255:0] b);
		for (int k = 0; k < 32; k++) begin
			if (a[8*k +: 8] != b[8*k +: 8]) return 1'b0;
			if (a[8*k +: 8] == 8'd0) return 1'b1;
		end
		return 1'b1;
	endfunction

	function automatic answer_t registry_step(logic [3:0] fn, logic [3:0] cls, logic [31:0] bus,
			logic [127:0] loc, logic [255:0] nm, logic [7:0] sel);
		answer_t r;
		logic slot_ok;
		logic live;
		int seen;
		int total;
		r.fail = 1'b1;
		r.ans = '0;
		r.nm = '0;
		slot_ok = (sel < DEPTH) && used[sel[6:0]];
		case (fn)
			FN_ADD: begin
				if (cls != 0 && nm[7:0] != 8'd0) begin
					// identical used entry answers its own slot
					for (int i = 0; i < DEPTH && r.fail; i++)
						if (used[i] && ent_cls[i] == cls && ent_bus[i] == bus &&
						    ent_loc[i] == loc && names_equal(ent_name[i], nm)) begin
							r.fail = 1'b0;
							r.ans = i;
						end
					// else lowest free slot
					for (int i = 0; i < DEPTH && r.fail; i++)
						if (!used[i]) begin
							used[i] = 1'b1;
							ent_cls[i] = cls;
							ent_bus[i] = bus;
							ent_loc[i] = loc;
							ent_name[i] = '0;
							live = 1'b1;
							for (int k = 0; k < 31; k++) begin
								if (nm[8*k +: 8] == 8'd0) live = 1'b0;
								if (live) ent_name[i][8*k +: 8] = nm[8*k +: 8];
							end
							ent_unit[i] = live_cnt[cls];
							if (live_cnt[cls] != 8'hFF) live_cnt[cls]++;
							r.fail = 1'b0;
							r.ans = i;
							adds_done++;
						end
					if (r.fail) full_hits++;
				end
			end
			FN_REMOVE: if (slot_ok) begin
				if (live_cnt[ent_cls[sel]] != 0) live_cnt[ent_cls[sel]]--;
				used[sel] = 1'b0;
				r.fail = 1'b0;
			end
			FN_COUNT_ALL: begin
				total = 0;
				for (int i = 0; i < DEPTH; i++) total += used[i];
				r.ans = total;
				r.fail = 1'b0;
			end
			FN_COUNT_CLASS: if (cls != 0) begin
				r.ans = live_cnt[cls];
				r.fail = 1'b0;
			end
			FN_NTH: if (cls != 0) begin
				seen = 0;
				for (int i = 0; i < DEPTH && r.fail; i++)
					if (used[i] && ent_cls[i] == cls) begin
						if (seen == sel) begin
							r.fail = 1'b0;
							r.ans = i;
						end
						seen++;
					end
			end
			FN_CLASS: if (slot_ok) begin r.ans = ent_cls[sel]; r.fail = 1'b0; end
			FN_UNIT: if (slot_ok) begin r.ans = ent_unit[sel]; r.fail = 1'b0; end
			FN_BUS: if (slot_ok) begin r.ans = ent_bus[sel]; r.fail = 1'b0; end
			FN_LOCATION: if (slot_ok && loc[31:0] <= 3) begin
				r.ans = ent_loc[sel][32*loc[1:0] +: 32];
				r.fail = 1'b0;
			end
			FN_NAME: if (slot_ok) begin r.nm = ent_name[sel]; r.fail = 1'b0; end
			default: ;
		endcase
		if (r.fail) begin
			r.ans = '0;
			r.nm = '0;
		end
		return r;
	endfunction

	assign pending = expected_q.size();

	initial begin
		errors = 0;
		checked = 0;
		adds_done = 0;
		full_hits = 0;
		for (int i = 0; i < DEPTH; i++) used[i] = 1'b0;
		for (int c = 0; c < NCLS; c++) live_cnt[c] = '0;
	end

	always @(posedge clk) begin
		answer_t e;
		logic [255:0] got_nm;
		if (arst_n) begin
			if (done) begin
				got_nm = {name_out_3, name_out_2, name_out_1, name_out_0};
				checked++;
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result: failed=%0b answer=%h", $time, failed,
						answer_value);
					errors++;
				end else begin
					e = expected_q.pop_front();
					if (failed !== e.fail) begin
						$display("%0t: failed: expected %0b, got %0b", $time, e.fail, failed);
						errors++;
					end
					if (answer_value !== e.ans) begin
						$display("%0t: answer_value: expected %h, got %h", $time, e.ans,
							answer_value);
						errors++;
					end
					if (got_nm !== e.nm) begin
						$display("%0t: name: expected %h, got %h", $time, e.nm, got_nm);
						errors++;
					end
				end
			end
			if (start && !busy)
				expected_q.push_back(registry_step(func, class_code, bus_number,
					{location_d, location_c, location_b, location_a},
					{name_word_3, name_word_2, name_word_1, name_word_0}, slot_select));
		end
	end
endmodule

FILE: test/tb.sv
// Testbench top: stimulus, idling and verdict for the device registry table.
`timescale 1ns / 100ps
module tb
	import drt_pkg::*;
;

	localparam int RANDOM_ITEMS = 2000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [3:0]  func;
	logic [3:0]  class_code;
	logic [31:0] bus_number;
	logic [31:0] location_a, location_b, location_c, location_d;
	logic [63:0] name_word_0, name_word_1, name_word_2, name_word_3;
	logic [7:0]  slot_select;
	logic        done;
	logic        failed;
	logic [31:0] answer_value;
	logic [63:0] name_out_0, name_out_1, name_out_2, name_out_3;

	int errors, pending, checked, adds_done, full_hits;
	int sent;
	int burst_left;

	// one request as the driver sees it
	typedef struct {
		logic [3:0]   fn;
		logic [3:0]   cls;
		logic [31:0]  bus;
		logic [127:0] loc;
		logic [255:0] nm;
		logic [7:0]   sel;
	} request_t;

	// recent add requests, replayed to hit the duplicate-entry path
	request_t recent_adds[8];
	int recent_fill;

	device_registry_table dut (
		.clk, .arst_n, .start, .busy, .func, .class_code, .bus_number,
		.location_a, .location_b, .location_c, .location_d,
		.name_word_0, .name_word_1, .name_word_2, .name_word_3,
		.slot_select, .done, .failed, .answer_value,
		.name_out_0, .name_out_1, .name_out_2, .name_out_3
	);

	drt_checker chk (
		.clk, .arst_n, .start, .busy, .func, .class_code, .bus_number,
		.location_a, .location_b, .location_c, .location_d,
		.name_word_0, .name_word_1, .name_word_2, .name_word_3,
		.slot_select, .done, .failed, .answer_value,
		.name_out_0, .name_out_1, .name_out_2, .name_out_3,
		.errors, .pending, .checked, .adds_done, .full_hits
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Name of len nonzero bytes; with junk set, random bytes follow the terminator,
	// which the table must ignore on match and drop on store.
	function automatic logic [255:0] make_name(int len, logic junk);
		logic [255:0] n;
		n = '0;
		for (int k = 0; k < 32; k++) begin
			if (k < len) n[8*k +: 8] = $urandom_range(1, 255);
			else if (junk && k > len) n[8*k +: 8] = $urandom_range(0, 255);
		end
		return n;
	endfunction

	function automatic request_t blank_request(logic [3:0] fn);
		request_t r;
		r.fn = fn;
		r.cls = '0;
		r.bus = '0;
		r.loc = '0;
		r.nm = '0;
		r.sel = '0;
		return r;
	endfunction

	function automatic request_t add_request(logic [3:0] cls, logic [31:0] bus, int len);
		request_t r;
		r = blank_request(FN_ADD);
		r.cls = cls;
		r.bus = bus;
		r.loc = {$urandom, $urandom, $urandom, $urandom};
		r.nm = make_name(len, 1'b0);
		return r;
	endfunction

	function automatic request_t query_request(logic [3:0] fn, logic [7:0] sel);
		request_t r;
		r = blank_request(fn);
		r.sel = sel;
		return r;
	endfunction

	// Random request; add_pct steers the fill level of the table.
	function automatic request_t random_request(int add_pct);
		request_t r;
		int pick;
		logic [255:0] junk;
		logic [255:0] keep;
		pick = $urandom_range(0, 99);
		r = blank_request(FN_COUNT_ALL);
		// noise on bus, location and name; unused fields must not matter
		if ($urandom_range(0, 3) == 0) begin
			r.bus = $urandom;
			r.loc = {$urandom, $urandom, $urandom, $urandom};
			r.nm = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom};
		end
		r.cls = $urandom_range(1, 15);
		r.sel = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 127));
		if (pick < add_pct) begin
			if (recent_fill > 0 && $urandom_range(0, 3) == 0) begin
				r = recent_adds[$urandom_range(0, recent_fill - 1)];
				// same name with different junk after the terminator still matches
				if ($urandom_range(0, 1) == 0)
					for (int k = 1; k < 31; k++)
						if (r.nm[8*k +: 8] == 8'd0 && r.nm[8*(k-1) +: 8] != 8'd0) begin
							junk = make_name(0, 1'b1);
							keep = (256'd1 << (8*k+8)) - 256'd1;
							r.nm = (r.nm & keep) | (junk & ~keep);
						end
			end else begin
				r.fn = FN_ADD;
				r.bus = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 3)) : $urandom;
				r.loc = {$urandom, $urandom, $urandom, $urandom};
				if ($urandom_range(0, 1) == 0) r.loc = {96'd0, 32'($urandom_range(0, 1))};
				r.nm = make_name($urandom_range(1, 32), 1'($urandom_range(0, 1)));
				if ($urandom_range(0, 15) == 0) r.nm[7:0] = 8'd0;
				if ($urandom_range(0, 15) == 0) r.cls = 4'd0;
				recent_adds[$urandom_range(0, 7)] = r;
				if (recent_fill < 8) recent_fill++;
			end
		end else begin
			pick = $urandom_range(0, 10);
			r.fn = (pick == 10) ? 4'($urandom_range(10, 15)) : 4'(pick);
			if (r.fn == FN_ADD) r.fn = FN_REMOVE;
			if ($urandom_range(0, 15) == 0) r.cls = 4'd0;
			if (r.fn == FN_NTH) r.sel = 8'($urandom_range(0, 20));
			if (r.fn == FN_LOCATION && $urandom_range(0, 7) != 0)
				r.loc[31:0] = $urandom_range(0, 3);
		end
		return r;
	endfunction

	// Present one transaction and hold it until the block takes it; the sender
	// idles between bursts so gaps land on every phase of the block's work.
	task automatic send(request_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		start       <= 1'b1;
		func        <= r.fn;
		class_code  <= r.cls;
		bus_number  <= r.bus;
		location_a  <= r.loc[31:0];
		location_b  <= r.loc[63:32];
		location_c  <= r.loc[95:64];
		location_d  <= r.loc[127:96];
		name_word_0 <= r.nm[63:0];
		name_word_1 <= r.nm[127:64];
		name_word_2 <= r.nm[191:128];
		name_word_3 <= r.nm[255:192];
		slot_select <= r.sel;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		sent++;
		@(negedge clk);
	endtask

	initial begin
		request_t r;
		int add_pct;
		arst_n = 1'b0;
		start = 1'b0;
		func = '0;
		class_code = '0;
		bus_number = '0;
		{location_a, location_b, location_c, location_d} = '0;
		{name_word_0, name_word_1, name_word_2, name_word_3} = '0;
		slot_select = '0;
		sent = 0;
		burst_left = 0;
		recent_fill = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: error cases, field extremes, every function
		send(add_request(4'd0, 32'd1, 5));                 // class zero rejected
		send(add_request(4'd3, 32'd1, 0));                 // empty name rejected
		r = add_request(4'd15, 32'h7FFF_FFFF, 31);
		r.loc = {4{32'hFFFF_FFFF}};
		send(r);                                           // slot 0, full-length name
		send(r);                                           // identical: same slot again
		r = add_request(4'd15, 32'h8000_0000, 32);         // byte 31 set: stored cut
		r.loc = '0;
		send(r);
		send(r);                                           // long name never matches
		r = add_request(4'd1, 32'h0, 3);
		r.nm[255:40] = {27{8'hA5}};                        // junk after the terminator
		send(r);
		send(query_request(FN_NAME, 8'd2));
		send(query_request(FN_NAME, 8'd0));
		send(query_request(FN_COUNT_ALL, 8'd0));
		r = query_request(FN_COUNT_CLASS, 8'd0);
		r.cls = 4'd15;
		send(r);
		r.cls = 4'd0;
		send(r);                                           // count of class zero fails
		r = query_request(FN_NTH, 8'd1);
		r.cls = 4'd15;
		send(r);
		r.sel = 8'd255;
		send(r);                                           // rank past the end
		r.cls = 4'd0;
		send(r);
		send(query_request(FN_CLASS, 8'd1));
		send(query_request(FN_UNIT, 8'd2));
		send(query_request(FN_BUS, 8'd1));
		for (int w = 0; w < 5; w++) begin                  // word index 4 fails
			r = query_request(FN_LOCATION, 8'd0);
			r.loc[31:0] = w;
			send(r);
		end
		send(query_request(FN_BUS, 8'd200));               // slot beyond the table
		send(query_request(FN_CLASS, 8'd100));             // unused slot
		send(query_request(FN_REMOVE, 8'd0));
		send(query_request(FN_REMOVE, 8'd0));              // already free
		send(query_request(4'd10, 8'd0));
		send(query_request(4'd15, 8'd255));

		// random: phases alternate between filling and draining the table,
		// so the full-table case and slot reuse both come up
		for (int p = 0; p < RANDOM_ITEMS / 200; p++) begin
			add_pct = (p % 3 == 1) ? 80 : (p % 3 == 2) ? 15 : 45;
			for (int i = 0; i < 200; i++) send(random_request(add_pct));
		end
		start <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		$display("Ran %0d transactions, %0d results checked, %0d new entries, %0d full adds",
			sent, checked, adds_done, full_hits);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Timeout: %0d results still outstanding", pending);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

FILE: files.f
sv/drt_pkg.sv
sv/drt_ram.sv
sv/device_registry_table.sv
test/drt_checker.sv
test/tb.sv
